// ===== rtl/shcl_pkg.sv =====
// Package with token codes, character constants and shared types of the command lexer.
`timescale 1ns / 1ps
`default_nettype none

package shcl_pkg;

  // Default limit on the number of characters kept for one word.
  localparam int MaxWordCharsDefault = 1023;

  typedef enum logic [3:0] {
    KIND_CHAR       = 4'd0,
    KIND_WORD_END   = 4'd1,
    KIND_PIPE       = 4'd2,
    KIND_INPUT      = 4'd3,
    KIND_OUTPUT     = 4'd4,
    KIND_APPEND     = 4'd5,
    KIND_BACKGROUND = 4'd6,
    KIND_SEMICOLON  = 4'd7,
    KIND_END        = 4'd8
  } token_kind_t;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_mode_t;

  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_LESS    = 8'h3C;
  localparam logic [7:0] CHAR_GREATER = 8'h3E;
  localparam logic [7:0] CHAR_PIPE    = 8'h7C;

  // Running lexer state, apart from the word length.
  typedef struct packed {
    logic        in_word;
    quote_mode_t quote_mode;
    logic        pending_greater;
  } lex_state_t;

  // Up to two tokens produced by one item.
  typedef struct packed {
    logic [1:0]  count;
    token_kind_t kind0;
    logic [7:0]  char0;
    token_kind_t kind1;
    logic [7:0]  char1;
  } step_out_t;

  // One queued result.
  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  word_char;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/shcl_step.sv =====
// Combinational tokenizer step: one byte or end marker in, state update and up to two tokens out.
`timescale 1ns / 1ps
`default_nettype none

module shcl_step #(
  parameter int MAX_WORD_CHARS = shcl_pkg::MaxWordCharsDefault,
  parameter int LenW           = $clog2(MAX_WORD_CHARS + 1)
) (
  input  wire logic [7:0]            byte_value,
  input  wire logic                  end_of_line,
  input  wire shcl_pkg::lex_state_t  state_cur,
  input  wire logic [LenW-1:0]       word_length,
  output shcl_pkg::lex_state_t       state_next,
  output logic [LenW-1:0]            word_length_next,
  output shcl_pkg::step_out_t        tokens
);
  import shcl_pkg::*;

  localparam logic [LenW-1:0] LenMax = LenW'(MAX_WORD_CHARS);

  function automatic void put(inout step_out_t o, input token_kind_t k, input logic [7:0] c);
    if (o.count == 2'd0) begin
      o.kind0 = k;
      o.char0 = c;
    end else begin
      o.kind1 = k;
      o.char1 = c;
    end
    o.count = o.count + 2'd1;
  endfunction

  logic       is_blank;
  logic       is_special;
  logic       do_take;
  logic [7:0] closer;

  assign is_blank   = ((byte_value >= CHAR_TAB) && (byte_value <= CHAR_CR)) ||
                      (byte_value == CHAR_SPACE);
  assign is_special = (byte_value == CHAR_PIPE) || (byte_value == CHAR_LESS) ||
                      (byte_value == CHAR_GREATER) || (byte_value == CHAR_AMP) ||
                      (byte_value == CHAR_SEMI);
  assign closer     = (state_cur.quote_mode == QUOTE_SINGLE) ? CHAR_SQUOTE : CHAR_DQUOTE;

  always_comb begin
    step_out_t o;
    lex_state_t s;
    logic [LenW-1:0] len;
    o        = '0;
    o.kind0  = KIND_CHAR;
    o.kind1  = KIND_CHAR;
    s        = state_cur;
    len      = word_length;
    do_take  = 1'b0;

    if (end_of_line) begin
      if (s.pending_greater) begin
        put(o, KIND_OUTPUT, 8'h00);
      end
      if (s.in_word && (len != '0)) begin
        put(o, KIND_WORD_END, 8'h00);
      end
      put(o, KIND_END, 8'h00);
      s   = '{in_word: 1'b0, quote_mode: QUOTE_NONE, pending_greater: 1'b0};
      len = '0;
    end else if (s.pending_greater) begin
      s.pending_greater = 1'b0;
      if (byte_value == CHAR_GREATER) begin
        put(o, KIND_APPEND, 8'h00);
      end else begin
        put(o, KIND_OUTPUT, 8'h00);
        do_take = 1'b1;
      end
    end else begin
      do_take = 1'b1;
    end

    if (do_take) begin
      if (s.quote_mode != QUOTE_NONE) begin
        // Inside quotes everything but the matching quote is a word character.
        if (byte_value == closer) begin
          s.quote_mode = QUOTE_NONE;
        end else if (len < LenMax) begin
          put(o, KIND_CHAR, byte_value);
          len = len + 1'b1;
        end
      end else if (is_blank) begin
        if (s.in_word) begin
          if (len != '0) begin
            put(o, KIND_WORD_END, 8'h00);
          end
          s.in_word = 1'b0;
          len       = '0;
        end
      end else if (is_special) begin
        if (s.in_word) begin
          if (len != '0) begin
            put(o, KIND_WORD_END, 8'h00);
          end
          s.in_word = 1'b0;
          len       = '0;
        end
        case (byte_value)
          CHAR_GREATER: s.pending_greater = 1'b1;
          CHAR_PIPE:    put(o, KIND_PIPE, 8'h00);
          CHAR_LESS:    put(o, KIND_INPUT, 8'h00);
          CHAR_AMP:     put(o, KIND_BACKGROUND, 8'h00);
          default:      put(o, KIND_SEMICOLON, 8'h00);
        endcase
      end else if ((byte_value == CHAR_SQUOTE) || (byte_value == CHAR_DQUOTE)) begin
        if (!s.in_word) begin
          s.in_word = 1'b1;
          len       = '0;
        end
        s.quote_mode = (byte_value == CHAR_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
      end else begin
        if (!s.in_word) begin
          s.in_word = 1'b1;
          len       = '0;
        end
        if (len < LenMax) begin
          put(o, KIND_CHAR, byte_value);
          len = len + 1'b1;
        end
      end
    end

    state_next       = s;
    word_length_next = len;
    tokens           = o;
  end

endmodule

`default_nettype wire

// ===== rtl/shcl_out_fifo.sv =====
// Four-entry result queue that takes up to two tokens per cycle and gives one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module shcl_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire shcl_pkg::step_out_t  tokens,
  output logic                      room,
  output logic                      token_valid,
  input  wire logic                 token_stall,
  output logic [3:0]                token_kind,
  output logic [7:0]                word_char,
  output logic                      last
);
  import shcl_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  result_t         entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [1:0]      push_n;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_plus1;

  assign push_n       = push ? tokens.count : 2'd0;
  assign pop          = token_valid && !token_stall;
  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign count_next   = count + CntW'(push_n) - CntW'(pop);

  // Two free slots are needed before the next item may be processed.
  assign room        = (count <= CntW'(Depth - 2));
  assign token_valid = (count != '0);
  assign token_kind  = entries[rd_ptr].kind;
  assign word_char   = entries[rd_ptr].word_char;
  assign last        = entries[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= '{kind: tokens.kind0, word_char: tokens.char0,
                           last: (tokens.count == 2'd1)};
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_plus1] <= '{kind: tokens.kind1, word_char: tokens.char1, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shell_command_lexer_unit.sv =====
// Top level of the streaming command-line lexer: input register, tokenizer step and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// cmd       cmd_valid / cmd_stall   byte_value[7:0], end_of_line
// token     token_valid / token_stall  token_kind[3:0], word_char[7:0], last
//
// Each command byte (or end marker) is captured in an input register and
// processed once the result queue has two free slots. One item per cycle is
// sustained while the queue has room; the token port delivers one result per
// cycle unless stalled, so the two tokens of one item leave it one after another.
// An accepted item passes the input register, then the queue, before its first token is on the port.
// Synchronous active-high reset empties the input register and the queue and
// clears the lexer state. A stalled token holds its payload until taken.

module shell_command_lexer_unit #(
  parameter int MAX_WORD_CHARS = shcl_pkg::MaxWordCharsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire logic [7:0] byte_value,
  input  wire logic       end_of_line,
  output logic            token_valid,
  input  wire logic       token_stall,
  output logic [3:0]      token_kind,
  output logic [7:0]      word_char,
  output logic            last
);
  import shcl_pkg::*;

  localparam int LenW = $clog2(MAX_WORD_CHARS + 1);

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eol;

  // Lexer state.
  lex_state_t      state;
  lex_state_t      state_next;
  logic [LenW-1:0] word_length;
  logic [LenW-1:0] word_length_next;

  step_out_t tokens;
  logic      room;
  logic      fire;
  logic      accept;

  // The held item is processed once the queue can take its worst case of two tokens.
  assign fire      = in_full && room;
  assign cmd_stall = in_full && !fire;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= byte_value;
      in_eol  <= end_of_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      state       <= '{in_word: 1'b0, quote_mode: QUOTE_NONE, pending_greater: 1'b0};
      word_length <= '0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        state       <= state_next;
        word_length <= word_length_next;
      end
    end
  end

  shcl_step #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS),
    .LenW           (LenW)
  ) u_step (
    .byte_value       (in_byte),
    .end_of_line      (in_eol),
    .state_cur        (state),
    .word_length      (word_length),
    .state_next       (state_next),
    .word_length_next (word_length_next),
    .tokens           (tokens)
  );

  shcl_out_fifo u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (fire),
    .tokens      (tokens),
    .room        (room),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_kind  (token_kind),
    .word_char   (word_char),
    .last        (last)
  );

endmodule

`default_nettype wire
